>>> sv/sbcf_pkg.sv
package sbcf_pkg;

  // Default widths
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int COEF_BITS_DEF    = 21;
  localparam int HISTORY_BITS_DEF = 32;

  // Configuration port
  localparam int CFG_W     = 63;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_ONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_TWO = 2'd2;

  // Gains and their fraction bits
  localparam int GAIN_W     = 16;
  localparam int DRIVE_FRAC = 12;
  localparam int MIX_FRAC   = 15;

  // Filter stages
  localparam int NUM_STAGES = 3;
  localparam int NUM_CH     = 2;
  localparam int STAGE_W    = 2;

  localparam logic [STAGE_W-1:0] STAGE_HP  = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_LP1 = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_LP2 = 2'd2;

  // Program counter and step addresses
  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_DRV_MUL  = 4'd1;
  localparam logic [PC_W-1:0] PC_DRV_WAIT = 4'd2;
  localparam logic [PC_W-1:0] PC_DRV_FIN  = 4'd3;
  localparam logic [PC_W-1:0] PC_BQ_M0    = 4'd4;
  localparam logic [PC_W-1:0] PC_BQ_M1    = 4'd5;
  localparam logic [PC_W-1:0] PC_BQ_M2    = 4'd6;
  localparam logic [PC_W-1:0] PC_BQ_M3    = 4'd7;
  localparam logic [PC_W-1:0] PC_BQ_M4    = 4'd8;
  localparam logic [PC_W-1:0] PC_BQ_WAIT  = 4'd9;
  localparam logic [PC_W-1:0] PC_BQ_FIN   = 4'd10;
  localparam logic [PC_W-1:0] PC_MIX_M0   = 4'd11;
  localparam logic [PC_W-1:0] PC_MIX_M1   = 4'd12;
  localparam logic [PC_W-1:0] PC_MIX_WAIT = 4'd13;
  localparam logic [PC_W-1:0] PC_MIX_FIN  = 4'd14;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd15;

  // Multiplier operand A source
  typedef enum logic [2:0] {
    OPA_RAW, OPA_X, OPA_XH1, OPA_XH2, OPA_YH1, OPA_YH2
  } opa_e;

  // Multiplier operand B source
  typedef enum logic [2:0] {
    OPB_B0, OPB_B1, OPB_A1, OPB_A2, OPB_DRIVE, OPB_DRY, OPB_WET
  } opb_e;

  // Rounding point and saturation target of a sum
  typedef enum logic [1:0] {
    KIND_DRV, KIND_BQ, KIND_MIX
  } kind_e;

  // Sequencing of the program counter
  typedef enum logic [2:0] {
    SEQ_NEXT, SEQ_WAIT_IN, SEQ_STAGE_LOOP, SEQ_CH_LOOP, SEQ_EMIT
  } seq_e;

  typedef struct packed {
    logic            mul_en;
    logic            first;
    opa_e            opa;
    opb_e            opb;
    kind_e           kind;
    logic            fin;
    seq_e            seq;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    ucode_t             uc;
    logic [STAGE_W-1:0] stage;
    logic               ch;
  } dp_ctrl_t;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = '{mul_en: 1'b0, first: 1'b0, opa: OPA_RAW, opb: OPB_B0, kind: KIND_DRV,
           fin: 1'b0, seq: SEQ_NEXT, target: PC_IDLE};
    case (pc)
      PC_IDLE: begin
        uc.seq = SEQ_WAIT_IN;
      end
      PC_DRV_MUL: begin
        uc.mul_en = 1'b1; uc.first = 1'b1; uc.opa = OPA_RAW; uc.opb = OPB_DRIVE;
        uc.kind = KIND_DRV;
      end
      PC_DRV_WAIT: begin
        uc.kind = KIND_DRV;
      end
      PC_DRV_FIN: begin
        uc.fin = 1'b1; uc.kind = KIND_DRV;
      end
      PC_BQ_M0: begin
        uc.mul_en = 1'b1; uc.first = 1'b1; uc.opa = OPA_X; uc.opb = OPB_B0;
        uc.kind = KIND_BQ;
      end
      PC_BQ_M1: begin
        uc.mul_en = 1'b1; uc.opa = OPA_XH1; uc.opb = OPB_B1; uc.kind = KIND_BQ;
      end
      PC_BQ_M2: begin
        uc.mul_en = 1'b1; uc.opa = OPA_XH2; uc.opb = OPB_B0; uc.kind = KIND_BQ;
      end
      PC_BQ_M3: begin
        uc.mul_en = 1'b1; uc.opa = OPA_YH1; uc.opb = OPB_A1; uc.kind = KIND_BQ;
      end
      PC_BQ_M4: begin
        uc.mul_en = 1'b1; uc.opa = OPA_YH2; uc.opb = OPB_A2; uc.kind = KIND_BQ;
      end
      PC_BQ_WAIT: begin
        uc.kind = KIND_BQ;
      end
      PC_BQ_FIN: begin
        uc.fin = 1'b1; uc.kind = KIND_BQ; uc.seq = SEQ_STAGE_LOOP; uc.target = PC_BQ_M0;
      end
      PC_MIX_M0: begin
        uc.mul_en = 1'b1; uc.first = 1'b1; uc.opa = OPA_RAW; uc.opb = OPB_DRY;
        uc.kind = KIND_MIX;
      end
      PC_MIX_M1: begin
        uc.mul_en = 1'b1; uc.opa = OPA_X; uc.opb = OPB_WET; uc.kind = KIND_MIX;
      end
      PC_MIX_WAIT: begin
        uc.kind = KIND_MIX;
      end
      PC_MIX_FIN: begin
        uc.fin = 1'b1; uc.kind = KIND_MIX; uc.seq = SEQ_CH_LOOP; uc.target = PC_DRV_MUL;
      end
      PC_EMIT: begin
        uc.seq = SEQ_EMIT; uc.target = PC_IDLE;
      end
      default: begin
        uc.seq = SEQ_NEXT;
      end
    endcase
    return uc;
  endfunction

endpackage

>>> sv/stereo_biquad_cabinet_filter.sv
// Stereo cabinet filter: each channel is scaled by drive, run through a
// biquad highpass and two biquad lowpasses (direct form I, coefficients
// shared by both channels, history per channel), and mixed with the dry
// input by the dry and wet gains, saturated to the sample width. A 16-step
// control store sequences one shared multiplier and accumulator through
// each channel in turn (drive, the three filters, mix) and then hands the
// result to the output register. A new input word is taken only once the
// result has been handed over and the sequencer is back at idle. The
// output register lets the next word start while a result still waits.
// Coefficient registers may be written only while the block is idle.
module stereo_biquad_cabinet_filter #(
  parameter int SAMPLE_BITS  = sbcf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS    = sbcf_pkg::COEF_BITS_DEF,
  parameter int HISTORY_BITS = sbcf_pkg::HISTORY_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  // left_in, right_in, drive_gain, dry_gain, wet_gain
  input  logic [((2*SAMPLE_BITS+3*sbcf_pkg::GAIN_W+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // left_out, right_out
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            m_axis_tdata,
  // clipped
  output logic [0:0]                                    m_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  input  logic                                          cfg_we_i,
  input  logic [sbcf_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [sbcf_pkg::CFG_W-1:0]                    cfg_data_i
);
  import sbcf_pkg::*;

  localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;

  dp_ctrl_t                      ctrl;
  logic                          in_ready, in_fire, out_free, out_load;
  logic signed [SAMPLE_BITS-1:0] left_res, right_res;
  logic                          clip_res;
  logic                          m_valid_q;
  logic [OUT_W-1:0]              m_data_q, out_word;
  logic                          m_user_q;

  assign s_axis_tready = in_ready;
  assign in_fire       = s_axis_tvalid & in_ready;
  assign out_free      = ~m_valid_q | m_axis_tready;

  sbcf_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .in_ready_o (in_ready),
    .out_load_o (out_load),
    .ctrl_o     (ctrl)
  );

  sbcf_datapath #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .COEF_BITS    (COEF_BITS),
    .HISTORY_BITS (HISTORY_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_load_i    (in_fire),
    .left_in_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .right_in_i   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .drive_gain_i (s_axis_tdata[2*SAMPLE_BITS+GAIN_W-1:2*SAMPLE_BITS]),
    .dry_gain_i   (s_axis_tdata[2*SAMPLE_BITS+2*GAIN_W-1:2*SAMPLE_BITS+GAIN_W]),
    .wet_gain_i   (s_axis_tdata[2*SAMPLE_BITS+3*GAIN_W-1:2*SAMPLE_BITS+2*GAIN_W]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .left_out_o   (left_res),
    .right_out_o  (right_res),
    .clipped_o    (clip_res)
  );

  // Pack result word, zero padded to bytes
  always_comb begin
    out_word                    = '0;
    out_word[2*SAMPLE_BITS-1:0] = {right_res, left_res};
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= out_word;
      m_user_q <= clip_res;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

endmodule

>>> sv/sbcf_sequencer.sv
module sbcf_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_free_i,
  output logic               in_ready_o,
  output logic               out_load_o,
  output sbcf_pkg::dp_ctrl_t ctrl_o
);
  import sbcf_pkg::*;

  logic [PC_W-1:0]    pc_q, pc_d;
  logic [STAGE_W-1:0] stage_q, stage_d;
  logic               ch_q, ch_d;
  ucode_t             uc;

  // Control word of the current step
  assign uc = ucode_rom(pc_q);

  assign ctrl_o.uc    = uc;
  assign ctrl_o.stage = stage_q;
  assign ctrl_o.ch    = ch_q;

  // Next step, loop counters and handshake strobes
  always_comb begin
    pc_d       = pc_q + 1'b1;
    stage_d    = stage_q;
    ch_d       = ch_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (uc.seq)
      SEQ_NEXT: begin
        pc_d = pc_q + 1'b1;
      end
      SEQ_WAIT_IN: begin
        in_ready_o = 1'b1;
        stage_d    = STAGE_HP;
        ch_d       = 1'b0;
        if (!in_valid_i) begin
          pc_d = pc_q;
        end
      end
      SEQ_STAGE_LOOP: begin
        if (stage_q != STAGE_LP2) begin
          stage_d = stage_q + 1'b1;
          pc_d    = uc.target;
        end else begin
          stage_d = STAGE_HP;
        end
      end
      SEQ_CH_LOOP: begin
        if (!ch_q) begin
          ch_d = 1'b1;
          pc_d = uc.target;
        end else begin
          ch_d = 1'b0;
        end
      end
      SEQ_EMIT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          pc_d       = uc.target;
        end else begin
          pc_d = pc_q;
        end
      end
      default: begin
        pc_d = uc.target;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PC_IDLE;
      stage_q <= STAGE_HP;
      ch_q    <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      stage_q <= stage_d;
      ch_q    <= ch_d;
    end
  end

  // Stage counter stays within the three filters
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q != 2'd3)
    else $error("stage counter out of range");

  // An accepted word starts the left channel at the first filter
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i) |=> (pc_q == PC_DRV_MUL && !ch_q && stage_q == STAGE_HP))
    else $error("item did not start at drive step");

  // A result waiting on a full output register holds the sequencer
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_EMIT && !out_free_i) |=> (pc_q == PC_EMIT))
    else $error("result dropped while output busy");

  // Loading the output returns to idle
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |=> (pc_q == PC_IDLE && in_ready_o))
    else $error("sequencer not idle after result load");

endmodule

>>> sv/sbcf_datapath.sv
module sbcf_datapath #(
  parameter int SAMPLE_BITS  = sbcf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS    = sbcf_pkg::COEF_BITS_DEF,
  parameter int HISTORY_BITS = sbcf_pkg::HISTORY_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sbcf_pkg::dp_ctrl_t                  ctrl_i,
  input  logic                                in_load_i,
  input  logic signed [SAMPLE_BITS-1:0]       left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]       right_in_i,
  input  logic [sbcf_pkg::GAIN_W-1:0]         drive_gain_i,
  input  logic [sbcf_pkg::GAIN_W-1:0]         dry_gain_i,
  input  logic [sbcf_pkg::GAIN_W-1:0]         wet_gain_i,
  input  logic                                cfg_we_i,
  input  logic [sbcf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sbcf_pkg::CFG_W-1:0]          cfg_data_i,
  output logic signed [SAMPLE_BITS-1:0]       left_out_o,
  output logic signed [SAMPLE_BITS-1:0]       right_out_o,
  output logic                                clipped_o
);
  import sbcf_pkg::*;

  localparam int AW      = (SAMPLE_BITS > HISTORY_BITS) ? SAMPLE_BITS : HISTORY_BITS;
  localparam int BW      = COEF_BITS + 2;
  localparam int PW      = AW + BW;
  localparam int ACC_W   = PW + 3;
  localparam int CW      = 3 * COEF_BITS;
  localparam int BQ_FRAC = COEF_BITS - 3;

  localparam logic signed [ACC_W-1:0] RND_DRV = ACC_W'(1) << (DRIVE_FRAC - 1);
  localparam logic signed [ACC_W-1:0] RND_BQ  = ACC_W'(1) << (BQ_FRAC - 1);
  localparam logic signed [ACC_W-1:0] RND_MIX = ACC_W'(1) << (MIX_FRAC - 1);

  localparam logic signed [ACC_W-1:0] H_MAX =
    {{(ACC_W-HISTORY_BITS+1){1'b0}}, {(HISTORY_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] H_MIN = ~H_MAX;
  localparam logic signed [ACC_W-1:0] S_MAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;

  ucode_t uc;
  assign uc = ctrl_i.uc;

  // Item, coefficient and history storage
  logic signed [SAMPLE_BITS-1:0]  raw_q [NUM_CH];
  logic [GAIN_W-1:0]              drive_q, dry_q, wet_q;
  logic [CW-1:0]                  coef_q [NUM_STAGES];
  logic signed [HISTORY_BITS-1:0] xh_q [NUM_STAGES][NUM_CH][2];
  logic signed [HISTORY_BITS-1:0] yh_q [NUM_STAGES][NUM_CH][2];
  logic signed [HISTORY_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0]  res_q [NUM_CH];
  logic                           clip_q [NUM_CH];

  // Multiply and accumulate pipeline
  logic signed [AW-1:0]    op_a;
  logic signed [BW-1:0]    op_b;
  logic signed [PW-1:0]    prod, prod_q;
  logic                    acc_en_q, first_q;
  kind_e                   kind_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, rnd;

  // Finish: round, shift, saturate
  logic signed [ACC_W-1:0]        shifted;
  logic signed [HISTORY_BITS-1:0] fin_h;
  logic signed [SAMPLE_BITS-1:0]  fin_s;
  logic                           fin_clip;

  // Coefficients of the active stage
  logic [CW-1:0]                coef_sel;
  logic signed [COEF_BITS-1:0]  b0, a1, a2;
  logic signed [BW-1:0]         b0_x, b2_x, b1_x, a1_x, a2_x;

  always_comb begin
    case (ctrl_i.stage)
      STAGE_HP:  coef_sel = coef_q[0];
      STAGE_LP1: coef_sel = coef_q[1];
      STAGE_LP2: coef_sel = coef_q[2];
      default:   coef_sel = '0;
    endcase
  end

  assign b0   = coef_sel[COEF_BITS-1:0];
  assign a1   = coef_sel[2*COEF_BITS-1:COEF_BITS];
  assign a2   = coef_sel[3*COEF_BITS-1:2*COEF_BITS];
  assign b0_x = BW'(b0);
  assign a1_x = BW'(a1);
  assign a2_x = BW'(a2);
  assign b2_x = {b0[COEF_BITS-1], b0, 1'b0};
  // highpass uses -2*b0, lowpasses +2*b0
  assign b1_x = (ctrl_i.stage == STAGE_HP) ? -b2_x : b2_x;

  // Operand A select
  always_comb begin
    case (uc.opa)
      OPA_RAW: op_a = AW'(raw_q[ctrl_i.ch]);
      OPA_X:   op_a = AW'(x_q);
      OPA_XH1: op_a = AW'(xh_q[ctrl_i.stage][ctrl_i.ch][0]);
      OPA_XH2: op_a = AW'(xh_q[ctrl_i.stage][ctrl_i.ch][1]);
      OPA_YH1: op_a = AW'(yh_q[ctrl_i.stage][ctrl_i.ch][0]);
      OPA_YH2: op_a = AW'(yh_q[ctrl_i.stage][ctrl_i.ch][1]);
      default: op_a = '0;
    endcase
  end

  // Operand B select
  always_comb begin
    case (uc.opb)
      OPB_B0:    op_b = b0_x;
      OPB_B1:    op_b = b1_x;
      OPB_A1:    op_b = a1_x;
      OPB_A2:    op_b = a2_x;
      OPB_DRIVE: op_b = {{(BW-GAIN_W){1'b0}}, drive_q};
      OPB_DRY:   op_b = {{(BW-GAIN_W){1'b0}}, dry_q};
      OPB_WET:   op_b = {{(BW-GAIN_W){1'b0}}, wet_q};
      default:   op_b = '0;
    endcase
  end

  assign prod = op_a * op_b;

  // First product of a sum is seeded with half an LSB of the result
  always_comb begin
    case (kind_q)
      KIND_DRV: rnd = RND_DRV;
      KIND_BQ:  rnd = RND_BQ;
      KIND_MIX: rnd = RND_MIX;
      default:  rnd = '0;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (acc_en_q) begin
      acc_d = (first_q ? rnd : acc_q) + ACC_W'(prod_q);
    end
  end

  always_comb begin
    case (uc.kind)
      KIND_DRV: shifted = acc_q >>> DRIVE_FRAC;
      KIND_BQ:  shifted = acc_q >>> BQ_FRAC;
      KIND_MIX: shifted = acc_q >>> MIX_FRAC;
      default:  shifted = acc_q;
    endcase
  end

  always_comb begin
    if (shifted > H_MAX) begin
      fin_h = H_MAX[HISTORY_BITS-1:0];
    end else if (shifted < H_MIN) begin
      fin_h = H_MIN[HISTORY_BITS-1:0];
    end else begin
      fin_h = shifted[HISTORY_BITS-1:0];
    end
  end

  always_comb begin
    fin_clip = 1'b0;
    if (shifted > S_MAX) begin
      fin_s    = S_MAX[SAMPLE_BITS-1:0];
      fin_clip = 1'b1;
    end else if (shifted < S_MIN) begin
      fin_s    = S_MIN[SAMPLE_BITS-1:0];
      fin_clip = 1'b1;
    end else begin
      fin_s = shifted[SAMPLE_BITS-1:0];
    end
  end

  // Control-side registers: coefficients, histories, accumulate strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        coef_q[s] <= '0;
        for (int c = 0; c < NUM_CH; c++) begin
          for (int a = 0; a < 2; a++) begin
            xh_q[s][c][a] <= '0;
            yh_q[s][c][a] <= '0;
          end
        end
      end
      acc_en_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HIGHPASS:    coef_q[0] <= cfg_data_i[CW-1:0];
          REG_LOWPASS_ONE: coef_q[1] <= cfg_data_i[CW-1:0];
          REG_LOWPASS_TWO: coef_q[2] <= cfg_data_i[CW-1:0];
          default: ;
        endcase
      end
      acc_en_q <= uc.mul_en;
      // stage done: shift both delay lines
      if (uc.fin && uc.kind == KIND_BQ) begin
        xh_q[ctrl_i.stage][ctrl_i.ch][1] <= xh_q[ctrl_i.stage][ctrl_i.ch][0];
        xh_q[ctrl_i.stage][ctrl_i.ch][0] <= x_q;
        yh_q[ctrl_i.stage][ctrl_i.ch][1] <= yh_q[ctrl_i.stage][ctrl_i.ch][0];
        yh_q[ctrl_i.stage][ctrl_i.ch][0] <= fin_h;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      raw_q[0] <= left_in_i;
      raw_q[1] <= right_in_i;
      drive_q  <= drive_gain_i;
      dry_q    <= dry_gain_i;
      wet_q    <= wet_gain_i;
    end
    prod_q  <= prod;
    first_q <= uc.first;
    kind_q  <= uc.kind;
    acc_q   <= acc_d;
    if (uc.fin) begin
      case (uc.kind)
        KIND_DRV, KIND_BQ: x_q <= fin_h;
        KIND_MIX: begin
          res_q[ctrl_i.ch]  <= fin_s;
          clip_q[ctrl_i.ch] <= fin_clip;
        end
        default: ;
      endcase
    end
  end

  assign left_out_o  = res_q[0];
  assign right_out_o = res_q[1];
  assign clipped_o   = clip_q[0] | clip_q[1];

endmodule
